// ===== design/dsec_pkg.sv =====
// ----------------------------------------------------------------------------
// dsec_pkg
// Shared types, constants and helpers for the delta stream edit counter.
// ----------------------------------------------------------------------------
package dsec_pkg;

   localparam int SIZE_BITS_DEFAULT = 32;
   localparam int EVT_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 2;

   localparam int EDIT_BITS = 32;
   localparam int ERR_BITS  = 3;
   localparam int AMT_BITS  = 17;

   localparam logic [2:0] MIN_LEN = 3'd6;

   localparam logic [7:0] CMD_COPY_BIT = 8'h80;
   localparam logic [7:0] CMD_FROM_DEST_BIT = 8'h40;
   localparam logic [7:0] COPY_ARG_MASK = 8'h3f;
   localparam logic [2:0] COPY_SIZE_LO_SHIFT = 3'd4;
   localparam logic [2:0] COPY_SIZE_HI_SHIFT = 3'd5;
   localparam logic [AMT_BITS-1:0] COPY_ZERO_SIZE = 17'h10000;

   localparam logic [ERR_BITS-1:0] ERR_OK       = 3'd0;
   localparam logic [ERR_BITS-1:0] ERR_SHORT    = 3'd1;
   localparam logic [ERR_BITS-1:0] ERR_TRUNC    = 3'd2;
   localparam logic [ERR_BITS-1:0] ERR_MISMATCH = 3'd3;
   localparam logic [ERR_BITS-1:0] ERR_OVERFLOW = 3'd4;

   typedef struct packed {
      logic                copy_en;
      logic                from_dest;
      logic                lit_en;
      logic                fin;
      logic [ERR_BITS-1:0] pre_err;
      logic [AMT_BITS-1:0] amount;
   } evt_type;

   function automatic logic [2:0] lowest_bit(input logic [7:0] m);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (m[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== design/dsec_fifo.sv =====
// ----------------------------------------------------------------------------
// dsec_fifo
// Small register based queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module dsec_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_CNT);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/dsec_front.sv =====
// ----------------------------------------------------------------------------
// dsec_front
// Byte parser: walks headers and commands and emits size events.
// ----------------------------------------------------------------------------
module dsec_front #(
   parameter int SIZE_BITS = dsec_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   last,
   output logic                   evt_push,
   output dsec_pkg::evt_type      evt,
   output logic [SIZE_BITS-1:0]   evt_src_size,
   output logic [SIZE_BITS-1:0]   evt_dst_size
);

   typedef enum logic [2:0] {
      PH_SRC_MASK,
      PH_SRC_BYTES,
      PH_DST_MASK,
      PH_DST_BYTES,
      PH_CMD,
      PH_COPY,
      PH_LIT
   } phase_type;

   localparam logic [63:0] SIZE_MASK = {64{1'b1}} >> (64 - SIZE_BITS);

   phase_type            phase_ff, phase_in;
   logic [7:0]           mask_ff, mask_in;
   logic [2:0]           shift_ff, shift_in;
   logic [SIZE_BITS-1:0] src_ff, src_in;
   logic [SIZE_BITS-1:0] dst_ff, dst_in;
   logic [15:0]          acc_ff, acc_in;
   logic                 from_dest_ff, from_dest_in;
   logic [6:0]           lit_left_ff, lit_left_in;
   logic [2:0]           len_ff, len_in;
   logic                 ovf_ff, ovf_in;
   logic [63:0]          hdr_value;
   logic                 hdr_ovf;
   logic [7:0]           mask_next;
   logic [15:0]          acc_sum;
   dsec_pkg::evt_type    evt_c;
   logic                 evt_valid_c;

   function automatic logic [dsec_pkg::AMT_BITS-1:0] AMT_EXT(input logic [7:0] b);
      return {{(dsec_pkg::AMT_BITS-8){1'b0}}, b};
   endfunction

   assign hdr_value = 64'(data_byte) << {shift_ff, 3'b000};
   assign hdr_ovf   = |(hdr_value & ~SIZE_MASK);
   assign mask_next = mask_ff & (mask_ff - 8'd1);

   always_comb begin
      acc_sum = acc_ff;
      if (shift_ff == dsec_pkg::COPY_SIZE_LO_SHIFT) begin
         acc_sum = acc_ff | {8'd0, data_byte};
      end else if (shift_ff == dsec_pkg::COPY_SIZE_HI_SHIFT) begin
         acc_sum = acc_ff | {data_byte, 8'd0};
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      mask_in      = mask_ff;
      shift_in     = shift_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      acc_in       = acc_ff;
      from_dest_in = from_dest_ff;
      lit_left_in  = lit_left_ff;
      len_in       = (len_ff < dsec_pkg::MIN_LEN) ? len_ff + 3'd1 : len_ff;
      ovf_in       = ovf_ff;
      evt_c        = '0;
      evt_valid_c  = 1'b0;

      case (phase_ff)
         PH_SRC_MASK, PH_DST_MASK: begin
            mask_in = data_byte;
            if (data_byte == 8'd0) begin
               phase_in = (phase_ff == PH_SRC_MASK) ? PH_DST_MASK : PH_CMD;
            end else begin
               shift_in = dsec_pkg::lowest_bit(data_byte);
               phase_in = (phase_ff == PH_SRC_MASK) ? PH_SRC_BYTES : PH_DST_BYTES;
            end
         end
         PH_SRC_BYTES, PH_DST_BYTES: begin
            if (hdr_ovf) begin
               ovf_in = 1'b1;
            end
            if (phase_ff == PH_SRC_BYTES) begin
               src_in = src_ff | hdr_value[SIZE_BITS-1:0];
            end else begin
               dst_in = dst_ff | hdr_value[SIZE_BITS-1:0];
            end
            mask_in = mask_next;
            if (mask_next == 8'd0) begin
               shift_in = 3'd0;
               phase_in = (phase_ff == PH_SRC_BYTES) ? PH_DST_MASK : PH_CMD;
            end else begin
               shift_in = dsec_pkg::lowest_bit(mask_next);
            end
         end
         PH_COPY: begin
            acc_in  = acc_sum;
            mask_in = mask_next & dsec_pkg::COPY_ARG_MASK;
            if ((mask_next & dsec_pkg::COPY_ARG_MASK) == 8'd0) begin
               shift_in          = 3'd0;
               phase_in          = PH_CMD;
               evt_valid_c       = 1'b1;
               evt_c.copy_en     = 1'b1;
               evt_c.from_dest   = from_dest_ff;
               evt_c.amount      = (acc_sum == 16'd0) ? dsec_pkg::COPY_ZERO_SIZE
                                                      : {1'b0, acc_sum};
            end else begin
               shift_in = dsec_pkg::lowest_bit(mask_next);
            end
         end
         PH_LIT: begin
            lit_left_in = lit_left_ff - 7'd1;
            if (lit_left_ff == 7'd1) begin
               phase_in = PH_CMD;
            end
         end
         default: begin
            if ((data_byte & dsec_pkg::CMD_COPY_BIT) != 8'd0) begin
               from_dest_in = (data_byte & dsec_pkg::CMD_FROM_DEST_BIT) != 8'd0;
               acc_in       = 16'd0;
               mask_in      = data_byte & dsec_pkg::COPY_ARG_MASK;
               if ((data_byte & dsec_pkg::COPY_ARG_MASK) == 8'd0) begin
                  phase_in        = PH_CMD;
                  evt_valid_c     = 1'b1;
                  evt_c.copy_en   = 1'b1;
                  evt_c.from_dest = from_dest_in;
                  evt_c.amount    = dsec_pkg::COPY_ZERO_SIZE;
               end else begin
                  shift_in = dsec_pkg::lowest_bit(data_byte & dsec_pkg::COPY_ARG_MASK);
                  phase_in = PH_COPY;
               end
            end else begin
               lit_left_in  = data_byte[6:0];
               phase_in     = (data_byte == 8'd0) ? PH_CMD : PH_LIT;
               evt_valid_c  = 1'b1;
               evt_c.lit_en = 1'b1;
               evt_c.amount = AMT_EXT(data_byte);
            end
         end
      endcase

      if (last) begin
         evt_valid_c = 1'b1;
         evt_c.fin   = 1'b1;
         if (len_in < dsec_pkg::MIN_LEN) begin
            evt_c.pre_err = dsec_pkg::ERR_SHORT;
         end else if (ovf_in) begin
            evt_c.pre_err = dsec_pkg::ERR_OVERFLOW;
         end else if (phase_in != PH_CMD) begin
            evt_c.pre_err = dsec_pkg::ERR_TRUNC;
         end else begin
            evt_c.pre_err = dsec_pkg::ERR_OK;
         end
      end
   end

   assign evt_push     = accept && evt_valid_c;
   assign evt          = evt_c;
   assign evt_src_size = src_in;
   assign evt_dst_size = dst_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         phase_ff     <= PH_SRC_MASK;
         mask_ff      <= '0;
         shift_ff     <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         acc_ff       <= '0;
         from_dest_ff <= 1'b0;
         lit_left_ff  <= '0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         mask_ff      <= mask_in;
         shift_ff     <= shift_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         acc_ff       <= acc_in;
         from_dest_ff <= from_dest_in;
         lit_left_ff  <= lit_left_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
      end
   end

endmodule

// ===== design/dsec_back.sv =====
// ----------------------------------------------------------------------------
// dsec_back
// Size accounting: keeps copy, literal and output totals, forms the result.
// ----------------------------------------------------------------------------
module dsec_back #(
   parameter int SIZE_BITS = dsec_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 evt_valid,
   input  dsec_pkg::evt_type                    evt,
   input  logic [SIZE_BITS-1:0]                 evt_src_size,
   input  logic [SIZE_BITS-1:0]                 evt_dst_size,
   output logic                                 evt_pop,
   input  logic                                 rsp_full,
   output logic                                 rsp_push,
   output logic [dsec_pkg::EDIT_BITS-1:0]       rsp_edit,
   output logic [dsec_pkg::ERR_BITS-1:0]        rsp_err
);

   logic [SIZE_BITS-1:0]          copied_ff, copied_in;
   logic [SIZE_BITS-1:0]          literal_ff, literal_in;
   logic [SIZE_BITS-1:0]          out_ff, out_in;
   logic                          over_ff, over_in;
   logic [SIZE_BITS-1:0]          amount;
   logic [SIZE_BITS+1:0]          out_sum;

   logic                          fin_ff;
   logic [SIZE_BITS-1:0]          fin_copied_ff, fin_literal_ff, fin_out_ff;
   logic [SIZE_BITS-1:0]          fin_src_ff, fin_dst_ff;
   logic                          fin_over_ff;
   logic [dsec_pkg::ERR_BITS-1:0] fin_err_ff;
   logic [SIZE_BITS-1:0]          edit_wide;
   logic [63:0]                   edit_ext;
   logic                          take_fin;

   assign amount  = SIZE_BITS'(evt.amount);
   assign evt_pop = evt_valid && (!evt.fin || !fin_ff || !rsp_full);
   assign take_fin = evt_pop && evt.fin;
   // full amount kept here, a 64k copy does not fit a 16 bit total
   assign out_sum = {2'b00, out_ff} + (SIZE_BITS+2)'(evt.amount);

   always_comb begin
      copied_in  = copied_ff;
      literal_in = literal_ff;
      out_in     = out_ff;
      over_in    = over_ff;
      if (evt_pop && evt.copy_en && !evt.from_dest) begin
         copied_in = copied_ff + amount;
      end
      if (evt_pop && evt.lit_en) begin
         literal_in = literal_ff + amount;
      end
      if (evt_pop && (evt.copy_en || evt.lit_en) && !over_ff) begin
         if (|out_sum[SIZE_BITS+1:SIZE_BITS]) begin
            over_in = 1'b1;
         end else begin
            out_in = out_sum[SIZE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || take_fin) begin
         copied_ff  <= '0;
         literal_ff <= '0;
         out_ff     <= '0;
         over_ff    <= 1'b0;
      end else begin
         copied_ff  <= copied_in;
         literal_ff <= literal_in;
         out_ff     <= out_in;
         over_ff    <= over_in;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else begin
         fin_ff <= take_fin || (fin_ff && rsp_full);
      end
   end

   always_ff @(posedge clock) begin
      if (take_fin) begin
         fin_copied_ff  <= copied_in;
         fin_literal_ff <= literal_in;
         fin_out_ff     <= out_in;
         fin_over_ff    <= over_in;
         fin_src_ff     <= evt_src_size;
         fin_dst_ff     <= evt_dst_size;
         fin_err_ff     <= evt.pre_err;
      end
   end

   always_comb begin
      if (fin_err_ff != dsec_pkg::ERR_OK) begin
         rsp_err = fin_err_ff;
      end else if (fin_over_ff || (fin_out_ff != fin_dst_ff)) begin
         rsp_err = dsec_pkg::ERR_MISMATCH;
      end else begin
         rsp_err = dsec_pkg::ERR_OK;
      end
      edit_wide = '0;
      if (rsp_err == dsec_pkg::ERR_OK) begin
         edit_wide = fin_src_ff - fin_copied_ff + fin_literal_ff;
      end
      edit_ext = 64'(edit_wide);
   end

   assign rsp_edit = edit_ext[dsec_pkg::EDIT_BITS-1:0];
   assign rsp_push = fin_ff && !rsp_full;

endmodule

// ===== design/delta_stream_edit_counter.sv =====
// ----------------------------------------------------------------------------
// delta_stream_edit_counter
// Parses a copy/insert delta byte stream and reports its edit size.
//
//   channel   ports                                  direction
//   request   req_push req_full req_data_byte        in
//             req_last
//   response  rsp_pop rsp_empty rsp_edit_size        out
//             rsp_error_code
//
// One byte is taken per cycle while the event queue has room; the parser
// updates its header and command state in that same cycle.
// The accounting stage drains one event per cycle except while a finished
// result waits on a full response queue; a result passes the event queue,
// the result registers and a small response queue. Reset is synchronous and
// empties both queues; the block then waits for a source header mask.
// A stalled response side backs up into the event queue and then raises
// req_full.
// ----------------------------------------------------------------------------
module delta_stream_edit_counter #(
   parameter int SIZE_BITS = dsec_pkg::SIZE_BITS_DEFAULT,
   parameter int EVT_DEPTH = dsec_pkg::EVT_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = dsec_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_last,
   input  logic                             rsp_pop,
   output logic                             rsp_empty,
   output logic [dsec_pkg::EDIT_BITS-1:0]   rsp_edit_size,
   output logic [dsec_pkg::ERR_BITS-1:0]    rsp_error_code
);

   localparam int EVT_BITS = $bits(dsec_pkg::evt_type);
   localparam int QW = EVT_BITS + 2 * SIZE_BITS;
   localparam int RW = dsec_pkg::EDIT_BITS + dsec_pkg::ERR_BITS;

   logic                 accept;
   logic                 f_push;
   dsec_pkg::evt_type    f_evt, b_evt;
   logic [SIZE_BITS-1:0] f_src, f_dst, b_src, b_dst;
   logic [QW-1:0]        q_rd;
   logic                 q_empty;
   logic                 b_pop;
   logic                 r_push, r_full;
   logic [dsec_pkg::EDIT_BITS-1:0] r_edit;
   logic [dsec_pkg::ERR_BITS-1:0]  r_err;
   logic [RW-1:0]        r_rd;

   assign accept = req_push && !req_full;

   dsec_front #(.SIZE_BITS(SIZE_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .last         (req_last),
      .evt_push     (f_push),
      .evt          (f_evt),
      .evt_src_size (f_src),
      .evt_dst_size (f_dst)
   );

   dsec_fifo #(.WIDTH(QW), .DEPTH(EVT_DEPTH)) u_evt_q (
      .clock   (clock),
      .reset   (reset),
      .push    (f_push),
      .wr_data ({f_evt, f_src, f_dst}),
      .pop     (b_pop),
      .rd_data (q_rd),
      .empty   (q_empty),
      .full    (req_full)
   );

   assign b_evt = q_rd[QW-1 -: EVT_BITS];
   assign b_src = q_rd[2*SIZE_BITS-1 -: SIZE_BITS];
   assign b_dst = q_rd[SIZE_BITS-1:0];

   dsec_back #(.SIZE_BITS(SIZE_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .evt_valid    (!q_empty),
      .evt          (b_evt),
      .evt_src_size (b_src),
      .evt_dst_size (b_dst),
      .evt_pop      (b_pop),
      .rsp_full     (r_full),
      .rsp_push     (r_push),
      .rsp_edit     (r_edit),
      .rsp_err      (r_err)
   );

   dsec_fifo #(.WIDTH(RW), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (r_push),
      .wr_data ({r_edit, r_err}),
      .pop     (rsp_pop),
      .rd_data (r_rd),
      .empty   (rsp_empty),
      .full    (r_full)
   );

   assign rsp_edit_size  = r_rd[RW-1 -: dsec_pkg::EDIT_BITS];
   assign rsp_error_code = r_rd[dsec_pkg::ERR_BITS-1:0];

endmodule

// ===== tb/delta_stream_edit_counter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_stream_edit_counter_test
// Self-checking bench for the delta stream edit counter. A short table of
// hand-built deltas opens the run, then random deltas follow, mostly well
// formed with random headers, copies and literals, plus noise and cut-off
// streams. Each accepted request byte runs through a local parser model;
// every result popped from the block is compared against the oldest
// predicted result. Both sides idle at random, and the response side holds
// off once for a long stretch so that the block fills up and backs up.
// ----------------------------------------------------------------------------
module delta_stream_edit_counter_test;

   localparam int SIZE_BITS = dsec_pkg::SIZE_BITS_DEFAULT;
   localparam logic [63:0] SIZE_MASK = {64{1'b1}} >> (64 - SIZE_BITS);
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BYTES = 950;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int HOLD_OFF_AFTER = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_GAP = 18;
   localparam int DIRECTED_ROWS = 25;

   typedef enum logic [2:0] {
      AWAIT_SRC_MASK,
      SRC_SIZE_BYTES,
      AWAIT_DST_MASK,
      DST_SIZE_BYTES,
      AWAIT_CMD,
      COPY_ARGS,
      LITERAL_PAYLOAD
   } parse_phase_type;

   typedef struct packed {
      logic [dsec_pkg::EDIT_BITS-1:0] edit_size;
      logic [dsec_pkg::ERR_BITS-1:0]  error_code;
   } edit_result_type;

   typedef struct {
      logic [7:0]                     data;
      logic                           last;
      bit                             typed;
      logic [dsec_pkg::EDIT_BITS-1:0] edit_size;
      logic [dsec_pkg::ERR_BITS-1:0]  error_code;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic                           req_full;
   logic [7:0]                     req_data_byte = 8'h00;
   logic                           req_last = 1'b0;
   logic                           rsp_pop = 1'b0;
   logic                           rsp_empty;
   logic [dsec_pkg::EDIT_BITS-1:0] rsp_edit_size;
   logic [dsec_pkg::ERR_BITS-1:0]  rsp_error_code;

   int cycle_count = 0;
   int error_count = 0;
   bit burst_tx = 1'b0;

   edit_result_type pending_results[$];
   logic [7:0]      delta_bytes[$];

   // parser model state
   parse_phase_type phase;
   logic [7:0]   arg_mask;
   logic [2:0]   arg_shift;
   logic [63:0]  src_len;
   logic [63:0]  dst_len;
   logic [63:0]  src_copied;
   logic [63:0]  lit_bytes;
   logic [63:0]  out_total;
   logic         out_over;
   logic [16:0]  copy_len;
   logic         copy_dest;
   logic [6:0]   lit_left;
   int           seen_bytes;
   logic [2:0]   first_err;

   // hand-built deltas, expected result given where it is obvious
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, 32'h0, dsec_pkg::ERR_SHORT},
      '{8'h10, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'hff, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h00, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h00, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h00, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h00, 1'b1, 1'b1, 32'h0, dsec_pkg::ERR_OVERFLOW},
      '{8'h00, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h00, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h05, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h01, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h02, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h03, 1'b1, 1'b1, 32'h0, dsec_pkg::ERR_TRUNC},
      '{8'h00, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h00, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h02, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h55, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'haa, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h00, 1'b1, 1'b1, 32'h0, dsec_pkg::ERR_MISMATCH},
      '{8'h00, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h04, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h02, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'h80, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'hc1, 1'b0, 1'b0, 32'h0, dsec_pkg::ERR_OK},
      '{8'haa, 1'b1, 1'b0, 32'h0, dsec_pkg::ERR_OK}
   };

   delta_stream_edit_counter i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_last       (req_last),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_edit_size  (rsp_edit_size),
      .rsp_error_code (rsp_error_code)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [2:0] lowest_set(input logic [7:0] m);
      int i;
      i = 0;
      while (i < 8 && !m[i]) i++;
      return (i == 8) ? 3'd0 : 3'(i);
   endfunction

   function automatic void clear_parser();
      phase = AWAIT_SRC_MASK;
      arg_mask = 8'h00;
      arg_shift = 3'd0;
      src_len = '0;
      dst_len = '0;
      src_copied = '0;
      lit_bytes = '0;
      out_total = '0;
      out_over = 1'b0;
      copy_len = '0;
      copy_dest = 1'b0;
      lit_left = '0;
      seen_bytes = 0;
      first_err = dsec_pkg::ERR_OK;
   endfunction

   function automatic void add_to_output(input logic [63:0] n);
      if (!out_over) begin
         if (n > SIZE_MASK - out_total) out_over = 1'b1;
         else out_total = out_total + n;
      end
   endfunction

   function automatic void close_copy();
      logic [63:0] amount;
      amount = (copy_len != '0) ? 64'(copy_len) : 64'(dsec_pkg::COPY_ZERO_SIZE);
      if (!copy_dest) src_copied = (src_copied + amount) & SIZE_MASK;
      add_to_output(amount);
      phase = AWAIT_CMD;
   endfunction

   // one request byte through the parser model
   function automatic void predict_byte(input logic [7:0] b, input logic fin,
                                        output bit produced,
                                        output edit_result_type res);
      logic [63:0] shifted;
      logic [2:0]  err;
      produced = 1'b0;
      res = '0;
      if (seen_bytes < dsec_pkg::MIN_LEN) seen_bytes++;
      case (phase)
         AWAIT_SRC_MASK, AWAIT_DST_MASK: begin
            arg_mask = b;
            if (b == 8'h00) begin
               if (phase == AWAIT_SRC_MASK) phase = AWAIT_DST_MASK;
               else phase = AWAIT_CMD;
            end else begin
               arg_shift = lowest_set(b);
               if (phase == AWAIT_SRC_MASK) phase = SRC_SIZE_BYTES;
               else phase = DST_SIZE_BYTES;
            end
         end
         SRC_SIZE_BYTES, DST_SIZE_BYTES: begin
            shifted = 64'(b) << (8 * arg_shift);
            if ((shifted & ~SIZE_MASK) != '0 && first_err == dsec_pkg::ERR_OK) begin
               first_err = dsec_pkg::ERR_OVERFLOW;
            end
            if (phase == SRC_SIZE_BYTES) src_len = src_len | (shifted & SIZE_MASK);
            else dst_len = dst_len | (shifted & SIZE_MASK);
            arg_mask = arg_mask & (arg_mask - 8'd1);
            if (arg_mask == 8'h00) begin
               arg_shift = 3'd0;
               if (phase == SRC_SIZE_BYTES) phase = AWAIT_DST_MASK;
               else phase = AWAIT_CMD;
            end else begin
               arg_shift = lowest_set(arg_mask);
            end
         end
         COPY_ARGS: begin
            if (arg_shift == dsec_pkg::COPY_SIZE_LO_SHIFT) begin
               copy_len = copy_len | {9'd0, b};
            end else if (arg_shift == dsec_pkg::COPY_SIZE_HI_SHIFT) begin
               copy_len = copy_len | {1'b0, b, 8'd0};
            end
            arg_mask = arg_mask & (arg_mask - 8'd1) & dsec_pkg::COPY_ARG_MASK;
            if (arg_mask == 8'h00) begin
               arg_shift = 3'd0;
               close_copy();
            end else begin
               arg_shift = lowest_set(arg_mask);
            end
         end
         LITERAL_PAYLOAD: begin
            lit_left = lit_left - 7'd1;
            if (lit_left == '0) phase = AWAIT_CMD;
         end
         default: begin
            if ((b & dsec_pkg::CMD_COPY_BIT) != 8'h00) begin
               copy_dest = (b & dsec_pkg::CMD_FROM_DEST_BIT) != 8'h00;
               copy_len = '0;
               arg_mask = b & dsec_pkg::COPY_ARG_MASK;
               if (arg_mask == 8'h00) begin
                  close_copy();
               end else begin
                  arg_shift = lowest_set(arg_mask);
                  phase = COPY_ARGS;
               end
            end else begin
               lit_bytes = (lit_bytes + 64'(b)) & SIZE_MASK;
               add_to_output(64'(b));
               lit_left = b[6:0];
               if (b != 8'h00) phase = LITERAL_PAYLOAD;
               else phase = AWAIT_CMD;
            end
         end
      endcase
      if (fin) begin
         if (seen_bytes < dsec_pkg::MIN_LEN) err = dsec_pkg::ERR_SHORT;
         else if (first_err != dsec_pkg::ERR_OK) err = first_err;
         else if (phase != AWAIT_CMD) err = dsec_pkg::ERR_TRUNC;
         else if (out_over || out_total != dst_len) err = dsec_pkg::ERR_MISMATCH;
         else err = dsec_pkg::ERR_OK;
         res.error_code = err;
         if (err == dsec_pkg::ERR_OK) begin
            res.edit_size = 32'((src_len - src_copied + lit_bytes) & SIZE_MASK);
         end
         produced = 1'b1;
         clear_parser();
      end
   endfunction

   function automatic void put_header(input logic [7:0] mask, input logic [63:0] size);
      delta_bytes.push_back(mask);
      for (int i = 0; i < 8; i++) begin
         if (mask[i]) delta_bytes.push_back(size[8*i +: 8]);
      end
   endfunction

   // mostly well-formed deltas, some noise, some cut short
   task automatic build_random_delta();
      logic [7:0]  cmd_bytes[$];
      logic [7:0]  src_mask;
      logic [7:0]  dst_mask;
      logic [7:0]  op;
      logic [7:0]  lit_len;
      logic [15:0] copy_field;
      logic [63:0] src_val;
      logic [63:0] dst_val;
      logic [63:0] out_sum;
      int          hi_bit;
      int          cut;
      delta_bytes.delete();
      if ($urandom_range(0, 15) == 0) begin
         repeat ($urandom_range(1, 12)) delta_bytes.push_back(8'($urandom));
         return;
      end
      src_val = {$urandom, $urandom};
      src_mask = 8'($urandom_range(0, 15));
      if ($urandom_range(0, 7) == 0) begin
         hi_bit = $urandom_range(4, 7);
         src_mask[hi_bit] = 1'b1;
         if ($urandom_range(0, 1) == 0) src_val[8*hi_bit +: 8] = 8'h00;
      end
      out_sum = '0;
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 19) == 0) lit_len = 8'($urandom_range(0, 127));
            else lit_len = 8'($urandom_range(0, 8));
            cmd_bytes.push_back(lit_len);
            repeat (lit_len) cmd_bytes.push_back(8'($urandom));
            out_sum = out_sum + 64'(lit_len);
         end else begin
            op = dsec_pkg::CMD_COPY_BIT
                 | (8'($urandom) & (dsec_pkg::CMD_FROM_DEST_BIT | dsec_pkg::COPY_ARG_MASK));
            if ($urandom_range(0, 3) == 0) copy_field = 16'($urandom_range(0, 3));
            else copy_field = 16'($urandom);
            cmd_bytes.push_back(op);
            for (int i = 0; i < dsec_pkg::COPY_SIZE_LO_SHIFT; i++) begin
               if (op[i]) cmd_bytes.push_back(8'($urandom));
            end
            if (op[dsec_pkg::COPY_SIZE_LO_SHIFT]) cmd_bytes.push_back(copy_field[7:0]);
            else copy_field[7:0] = 8'h00;
            if (op[dsec_pkg::COPY_SIZE_HI_SHIFT]) cmd_bytes.push_back(copy_field[15:8]);
            else copy_field[15:8] = 8'h00;
            if (copy_field == 16'h0000) begin
               out_sum = out_sum + 64'(dsec_pkg::COPY_ZERO_SIZE);
            end else begin
               out_sum = out_sum + 64'(copy_field);
            end
         end
      end
      dst_val = out_sum;
      if ($urandom_range(0, 9) == 0) dst_val = dst_val + 64'($urandom_range(1, 3));
      dst_mask = 8'h00;
      for (int i = 0; i < 4; i++) begin
         if (dst_val[8*i +: 8] != 8'h00 || $urandom_range(0, 3) == 0) dst_mask[i] = 1'b1;
      end
      put_header(src_mask, src_val);
      put_header(dst_mask, dst_val);
      foreach (cmd_bytes[i]) delta_bytes.push_back(cmd_bytes[i]);
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, 3);
         while (cut > 0 && delta_bytes.size() > 1) begin
            void'(delta_bytes.pop_back());
            cut--;
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                            input logic [dsec_pkg::EDIT_BITS-1:0] typed_edit,
                            input logic [dsec_pkg::ERR_BITS-1:0] typed_err);
      int              gap;
      bit              produced;
      edit_result_type predicted;
      gap = burst_tx ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= b;
      req_last <= fin;
      do @(posedge clock); while (req_full);
      predict_byte(b, fin, produced, predicted);
      if (produced) begin
         if (typed) begin
            predicted.edit_size = typed_edit;
            predicted.error_code = typed_err;
         end
         pending_results.push_back(predicted);
      end
   endtask

   initial begin : request_side
      int random_bytes;
      clear_parser();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].edit_size, directed_rows[i].error_code);
      end
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         build_random_delta();
         burst_tx = ($urandom_range(0, 3) == 0);
         foreach (delta_bytes[i]) begin
            send_byte(delta_bytes[i], i == delta_bytes.size() - 1, 1'b0, '0,
                      dsec_pkg::ERR_OK);
         end
         random_bytes += delta_bytes.size();
      end
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : response_side
      int              pop_gap;
      int              results_seen;
      bit              burst_rx;
      edit_result_type wanted;
      results_seen = 0;
      burst_rx = 1'b0;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 15) == 0) burst_rx = !burst_rx;
         // long hold-off so the request side backs up
         if (results_seen == HOLD_OFF_AFTER) pop_gap = HOLD_OFF_CYCLES;
         else if (burst_rx) pop_gap = 0;
         else pop_gap = $urandom_range(0, MAX_GAP);
         if (pop_gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (pop_gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual edit_size %h error_code %0d",
                     $time, rsp_edit_size, rsp_error_code);
            error_count++;
         end else begin
            wanted = pending_results.pop_front();
            if (rsp_edit_size !== wanted.edit_size) begin
               $display("%0t: edit_size mismatch, expected %h, actual %h",
                        $time, wanted.edit_size, rsp_edit_size);
               error_count++;
            end
            if (rsp_error_code !== wanted.error_code) begin
               $display("%0t: error_code mismatch, expected %0d, actual %0d",
                        $time, wanted.error_code, rsp_error_code);
               error_count++;
            end
         end
      end
   end

endmodule
